// File: rtl/fp8c_pkg.sv
// Package for the FP8 (E3M4) conversion core: constants and stage types.
// No dependencies.
`default_nettype none
package fp8c_pkg;
    localparam int QWidth = 34;
    localparam logic [7:0] InfCode = 8'h70;
    localparam logic [7:0] NanCode = 8'h7C;
    localparam logic CmdSingle = 1'b0;
    localparam logic CmdFixed = 1'b1;

    // Stage one result: sign, special-case flags and the aligned magnitude.
    typedef struct packed {
        logic              sign;
        logic              force_code;
        logic [6:0]        code;
        logic [QWidth-1:0] q;
    } stage1_t;

    // Stage two result: leading-one position and aligned magnitude.
    typedef struct packed {
        logic              sign;
        logic              force_code;
        logic [6:0]        code;
        logic [QWidth-1:0] q;
        logic [5:0]        base;
    } stage2_t;
endpackage
`default_nettype wire

// File: rtl/fixed_or_single_to_fp8_e3m4_core.sv
// Top level of the FP8 E3M4 conversion core: three register stages.
// Depends on fp8c_pkg and fp8c_round.
`default_nettype none
// Converts an IEEE single or a signed Q21.10 fixed-point word to FP8 E3M4
// with round to nearest even. One transaction is accepted per cycle (busy
// is always low) and its result appears with done once it has passed
// stage one, which decodes and aligns, stage two, which finds the leading
// one, and stage three, which rounds. The receiver cannot stall the core.
module fixed_or_single_to_fp8_e3m4_core
    import fp8c_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    output logic         busy,
    input  wire          cmd,
    input  wire  [31:0]  operand,
    output logic         done,
    output logic [7:0]   fp8_code
);
    logic    v1_reg, v2_reg, v3_reg;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    logic [7:0] code_reg, code_next;

    assign busy = 1'b0;

    // Stage one: decode and align to Q*2^-30.
    always_comb
    begin
        logic [7:0]  e;
        logic [31:0] mag;
        logic        big;
        e = operand[30:23];
        mag = operand[31] ? (~operand + 32'd1) : operand;
        big = 1'b0;
        s1_next = '0;
        s1_next.sign = operand[31];
        if (cmd == CmdSingle)
        begin
            if (e == 8'hFF)
            begin
                s1_next.force_code = 1'b1;
                s1_next.code = (operand[22:0] == '0) ? InfCode[6:0] : NanCode[6:0];
            end
            else if (e < 8'd120)
            begin
                s1_next.force_code = 1'b1;
            end
            else if (e >= 8'd131)
            begin
                big = 1'b1;
            end
            else
            begin
                s1_next.q = QWidth'({1'b1, operand[22:0]}) << (e - 8'd120);
            end
        end
        else
        begin
            if (operand[31] && mag == '0)
            begin
                big = 1'b1;
            end
            else if (mag >= 32'd16384)
            begin
                big = 1'b1;
            end
            else
            begin
                s1_next.q = QWidth'(mag) << 20;
            end
        end
        if (!s1_next.force_code)
        begin
            if (big || s1_next.q >= (QWidth'(63) << 28))
            begin
                s1_next.force_code = 1'b1;
                s1_next.code = InfCode[6:0];
            end
            else if (s1_next.q <= (QWidth'(1) << 23))
            begin
                s1_next.force_code = 1'b1;
                s1_next.code = '0;
            end
        end
    end

    // Stage two: leading-one position, floored at the subnormal boundary.
    always_comb
    begin
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < QWidth; i++)
        begin
            if (s1_reg.q[i])
            begin
                p = 6'(i);
            end
        end
        s2_next.sign = s1_reg.sign;
        s2_next.force_code = s1_reg.force_code;
        s2_next.code = s1_reg.code;
        s2_next.q = s1_reg.q;
        s2_next.base = (p < 6'd28) ? 6'd28 : p;
    end

    fp8c_round u_round (
        .s2   (s2_reg),
        .code (code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        code_reg <= code_next;
    end

    assign done = v3_reg;
    assign fp8_code = code_reg;

    // An accepted transaction must give a result with done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done) else $error("result lost in pipeline");
    // A positive result never has the sign bit set.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !s2_reg.sign |=> !fp8_code[7]) else $error("sign flipped");
    // Results only follow accepted transactions.
    a_noinv: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3)) else $error("spurious result");
endmodule
`default_nettype wire

// File: rtl/fp8c_round.sv
// Final pipeline stage logic of the FP8 core: rounding to nearest even.
// Depends on fp8c_pkg.
`default_nettype none
module fp8c_round
    import fp8c_pkg::*;
(
    input  wire stage2_t s2,
    output logic [7:0]   code
);
    logic [5:0]        shift;
    logic [QWidth-1:0] t;
    logic [QWidth-1:0] rem;
    logic [QWidth-1:0] half;
    logic [QWidth-1:0] mask;
    logic [7:0]        sum;

    always_comb
    begin
        shift = s2.base - 6'd4;
        t     = s2.q >> shift;
        mask  = (QWidth'(1) << shift) - QWidth'(1);
        rem   = s2.q & mask;
        half  = QWidth'(1) << (shift - 6'd1);
        if (rem > half || (rem == half && t[0]))
        begin
            t = t + QWidth'(1);
        end
        sum = {2'b00, (s2.base - 6'd28)} << 4;
        sum = sum + t[7:0];
        if (s2.force_code)
        begin
            code = {s2.sign, s2.code};
        end
        else
        begin
            code = {s2.sign, sum[6:0]};
        end
    end
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for fixed_or_single_to_fp8_e3m4_core: drives IEEE single and fixed-point
// operands, predicts each FP8 E3M4 code and checks it against the done strobe.
// Depends on fp8c_pkg and the core RTL.
`timescale 1ns / 100ps
module testbench;
    import fp8c_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [31:0] operand;
    } conv_req_t;

    localparam int WatchdogLimit = 2000;
    localparam int TailCycles = 10;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       cmd;
    logic [31:0] operand;
    wire        busy;
    wire        done;
    wire  [7:0] fp8_code;

    conv_req_t  pending_reqs[$];
    logic [7:0] expected_codes[$];
    int         mismatches;
    int         idle_count;
    int         watchdog;
    bit         stimulus_done;
    bit         drain_pause;
    bit         no_idling;

    fixed_or_single_to_fp8_e3m4_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .operand(operand), .done(done), .fp8_code(fp8_code)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Rounds a magnitude held as q * 2^-30 to the E3M4 field with the sign attached.
    function automatic logic [7:0] encode_magnitude(logic sign, logic big, logic [33:0] q);
        logic [7:0] s;
        int         msb;
        int         base;
        int         shift;
        logic [33:0] t;
        logic [33:0] rem;
        logic [33:0] half;
        s = {sign, 7'd0};
        if (big || q >= (34'd63 << 28))
            return s | InfCode;
        if (q <= (34'd1 << 23))
            return s;
        msb = 0;
        for (int i = 33; i >= 0; i--)
        begin
            if (q[i])
            begin
                msb = i;
                break;
            end
        end
        base = (msb < 28) ? 28 : msb;
        shift = base - 4;
        t = q >> shift;
        rem = q & ((34'd1 << shift) - 34'd1);
        half = 34'd1 << (shift - 1);
        if (rem > half || (rem == half && t[0]))
            t = t + 34'd1;
        return s | 8'(((base - 28) << 4) + int'(t));
    endfunction

    function automatic logic [7:0] predict_code(conv_req_t req);
        logic        sign;
        logic [7:0]  expo;
        logic [33:0] mant;
        logic [32:0] mag;
        sign = req.operand[31];
        if (req.cmd == CmdSingle)
        begin
            expo = req.operand[30:23];
            if (expo == 8'hFF)
                return {sign, 7'd0} | ((req.operand[22:0] == 0) ? InfCode : NanCode);
            if (expo < 8'd120)
                return {sign, 7'd0};
            if (expo >= 8'd131)
                return encode_magnitude(sign, 1'b1, '0);
            mant = {11'd0, 1'b1, req.operand[22:0]};
            return encode_magnitude(sign, 1'b0, mant << (expo - 8'd120));
        end
        mag = sign ? {1'b0, (~req.operand + 32'd1)} : {1'b0, req.operand};
        if (sign && mag == 0)
            mag = 33'd1 << 31;
        if (mag >= (33'd16 << 10))
            return encode_magnitude(sign, 1'b1, '0);
        return encode_magnitude(sign, 1'b0, 34'(mag) << 20);
    endfunction

    function automatic conv_req_t random_req();
        conv_req_t r;
        int        pick;
        r.cmd = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (r.cmd == CmdSingle)
        begin
            // Mostly exponents in or near the representable span.
            if (pick < 7)
                r.operand = {1'($urandom), 8'($urandom_range(116, 134)), 23'($urandom)};
            else
                r.operand = $urandom;
        end
        else
        begin
            if (pick < 7)
                r.operand = 32'($signed($urandom_range(0, 40000)) - 20000);
            else
                r.operand = $urandom;
        end
        return r;
    endfunction

    initial
    begin
        logic [31:0] directed_ops[] = '{
            32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFF800001, 32'h00000000,
            32'h80000000, 32'h00000001, 32'h3C000000, 32'h3C000001, 32'h41780000,
            32'h417BFFFF, 32'h3E780000, 32'h3E7C0000, 32'hC1700000, 32'h7F7FFFFF};
        logic [31:0] directed_fix[] = '{
            32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000008,
            32'h00000009, 32'h00003F00, 32'hFFFFC100, 32'h000000FC, 32'h00000400};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = 1'b0;
        operand = '0;
        mismatches = 0;
        stimulus_done = 1'b0;
        foreach (directed_ops[i])
            pending_reqs.push_back('{CmdSingle, directed_ops[i]});
        foreach (directed_fix[i])
            pending_reqs.push_back('{CmdFixed, directed_fix[i]});
        for (int i = 0; i < 650; i++)
            pending_reqs.push_back(random_req());
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: one transaction per cycle from pending_reqs unless idling or paused.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            no_idling = pending_reqs.size() < 100;
            if (drain_pause && expected_codes.size() == 0 && !start)
                drain_pause <= 1'b0;
            if (idle_count > 0)
            begin
                idle_count <= idle_count - 1;
                start <= 1'b0;
            end
            else if (drain_pause || pending_reqs.size() == 0)
                start <= 1'b0;
            else if (!no_idling && $urandom_range(0, 15) == 0)
            begin
                idle_count <= $urandom_range(0, 9);
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                cmd <= pending_reqs[0].cmd;
                operand <= pending_reqs[0].operand;
            end
        end
    end

    initial
    begin
        idle_count = 0;
        drain_pause = 1'b0;
    end

    // Monitor: records accepted transactions and checks each strobed result.
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (start && !busy)
            begin
                expected_codes.push_back(predict_code('{cmd, operand}));
                void'(pending_reqs.pop_front());
                if (pending_reqs.size() == 300)
                    drain_pause <= 1'b1;
            end
            if (done)
            begin
                if (expected_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %02h", fp8_code);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (fp8_code !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("fp8_code mismatch: expected %02h, got %02h",
                                     want, fp8_code);
                    end
                end
            end
        end
        else
            watchdog <= 0;
    end

    initial
    begin
        wait (rst_n);
        fork
            begin
                wait (pending_reqs.size() == 0 && expected_codes.size() == 0);
                repeat (TailCycles) @(posedge clk);
                if (mismatches == 0 && expected_codes.size() == 0)
                    $display("fixed_or_single_to_fp8_e3m4_core verification clean");
                else
                    $display("fixed_or_single_to_fp8_e3m4_core verification failed");
                $finish;
            end
            begin
                wait (watchdog >= WatchdogLimit);
                $display("fixed_or_single_to_fp8_e3m4_core verification failed");
                $finish;
            end
        join
    end
endmodule

// File: fixed_or_single_to_fp8_e3m4_core.f
rtl/fp8c_pkg.sv
rtl/fp8c_round.sv
rtl/fixed_or_single_to_fp8_e3m4_core.sv
sim/testbench.sv
